@@ rtl/hmmd_pkg.sv @@
// Shared types and constants for the handheld memory map decoder.
`default_nettype none
package hmmd_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned DataW   = 8;
  localparam int unsigned TgtW    = 4;
  localparam int unsigned BankW   = 3;
  localparam int unsigned BankBytes = 4096;
  localparam int unsigned IoBytes = 128;
  localparam int unsigned HramBytes = 128;
  localparam int unsigned OffW    = $clog2(BankBytes);
  localparam int unsigned WramAw  = OffW + BankW;
  localparam int unsigned IoAw    = $clog2(IoBytes);
  localparam int unsigned HramAw  = $clog2(HramBytes);
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 40;

  // work RAM bank select and boot ROM disable latch
  localparam logic [AddrW-1:0] AddrBank = 16'hFF70;
  localparam logic [AddrW-1:0] AddrBoot = 16'hFF50;

  typedef enum logic [TgtW-1:0] {
    TGT_INTERNAL = 4'd0,
    TGT_CART     = 4'd1,
    TGT_BOOT     = 4'd2,
    TGT_VIDEO    = 4'd3,
    TGT_AUDIO    = 4'd4,
    TGT_CPU      = 4'd5,
    TGT_JOYPAD   = 4'd6,
    TGT_TIMER    = 4'd7,
    TGT_SERIAL   = 4'd8,
    TGT_IRQ      = 4'd9
  } tgt_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;  // capture the incoming request
    logic access;    // perform storage read/write for the held request
    logic load_out;  // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } status_t;

endpackage
`default_nettype wire

@@ rtl/handheld_memory_map_decoder.sv @@
// Top level of the handheld memory map decoder.
//
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+-------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready | op, address, write_data
//  m_axis   | out | m_axis_tvalid/m_axis_tready | target, forwarded fields, read
//  cfg      | in  | cfg_valid_i/cfg_ready_o     | cartridge_present
//
// An access is sequenced as capture, storage access and result load: the
// accepting edge captures the request, a registered read/write of the
// single-port storage follows, and the output register is then loaded; only
// after that load is a new request taken. The output register holds a
// finished result while the next request is accepted. Reset (rst_ni low,
// asynchronous) sets bank 1, enables the boot ROM, marks a cartridge present
// and clears the I/O register file.
// A stall on m_axis holds the sequencer in its last step.
`default_nettype none
module handheld_memory_map_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [hmmd_pkg::InDataW-1:0]  s_axis_tdata,  // address, write_data
  input  wire logic                          s_axis_tuser,  // op
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // forward_address, forward_write, forward_data, read_data, read_valid, zero pad
  output logic [hmmd_pkg::OutDataW-1:0]      m_axis_tdata,
  output logic [hmmd_pkg::TgtW-1:0]          m_axis_tuser,  // target
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_data_i
);

  hmmd_pkg::cmd_t    cmd;
  hmmd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  hmmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hmmd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .req_op_i    (s_axis_tuser),
    .req_data_i  (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tgt_o   (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/hmmd_ctrl.sv @@
// Request sequencer: capture, storage access, result load.
`default_nettype none
module hmmd_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire hmmd_pkg::status_t status_i,
  output hmmd_pkg::cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACCESS,
    S_FORM
  } state_e;

  state_e state_q;
  logic   rdy_q;

  always_comb begin
    cmd_o.load_req = req_valid_i && rdy_q;
    cmd_o.access   = (state_q == S_ACCESS);
    cmd_o.load_out = (state_q == S_FORM) && status_i.out_free;
  end

  assign req_ready_o = rdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i && rdy_q) begin
            state_q <= S_ACCESS;
            rdy_q   <= 1'b0;
          end
        end
        S_ACCESS: begin
          state_q <= S_FORM;
        end
        S_FORM: begin
          // hold until the output slot can take the result
          if (status_i.out_free) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdy_q |-> state_q == S_IDLE)
    else $error("ready raised outside idle");

  a_accept_then_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |=> state_q == S_ACCESS && !rdy_q)
    else $error("accepted request did not start access");

  a_access_then_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACCESS |=> state_q == S_FORM)
    else $error("access not followed by result forming");

endmodule
`default_nettype wire

@@ rtl/hmmd_dp.sv @@
// Datapath: request registers, address decode, work RAM, I/O file, high RAM.
`default_nettype none
module hmmd_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_data_i,
  input  wire logic                          req_op_i,
  input  wire logic [hmmd_pkg::InDataW-1:0]  req_data_i,
  input  wire hmmd_pkg::cmd_t                cmd_i,
  output hmmd_pkg::status_t                  status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [hmmd_pkg::TgtW-1:0]          out_tgt_o,
  output logic [hmmd_pkg::OutDataW-1:0]      out_data_o
);

  typedef enum logic [2:0] {
    K_FWD,
    K_FILL,
    K_ZERO,
    K_WRAM,
    K_IO,
    K_HRAM
  } kind_e;

  localparam logic [7:0]  FillByte = 8'hFF;
  localparam logic [7:0]  BankSetBits = 8'hF8;
  localparam logic [hmmd_pkg::IoAw-1:0] BootIdx = hmmd_pkg::IoAw'(hmmd_pkg::AddrBoot);

  // request registers
  logic                         wr_q;
  logic [hmmd_pkg::AddrW-1:0]   addr_q;
  logic [hmmd_pkg::DataW-1:0]   wdata_q;

  // control state
  logic                         cart_q;
  logic [hmmd_pkg::BankW-1:0]   bank_q;
  logic [hmmd_pkg::DataW-1:0]   boot_q;
  logic [hmmd_pkg::IoBytes-1:0] io_vld_q;
  logic                         io_rv_q;
  logic                         out_valid_q;

  // storage
  logic [hmmd_pkg::DataW-1:0] wram_mem [2**hmmd_pkg::WramAw];
  logic [hmmd_pkg::DataW-1:0] io_mem   [hmmd_pkg::IoBytes];
  logic [hmmd_pkg::DataW-1:0] hram_mem [hmmd_pkg::HramBytes];
  logic [hmmd_pkg::DataW-1:0] wram_rd_q;
  logic [hmmd_pkg::DataW-1:0] io_rd_q;
  logic [hmmd_pkg::DataW-1:0] hram_rd_q;

  logic [hmmd_pkg::TgtW-1:0]     out_tgt_q;
  logic [hmmd_pkg::OutDataW-1:0] out_data_q;

  // decode
  hmmd_pkg::tgt_e              own_tgt, tgt;
  logic                        owned;
  kind_e                       kind;
  logic [7:0]                  lo;
  logic                        boot_on;
  logic [hmmd_pkg::WramAw-1:0] widx;
  logic [hmmd_pkg::IoAw-1:0]   iidx;
  logic [hmmd_pkg::HramAw-1:0] hidx;
  logic [hmmd_pkg::DataW-1:0]  io_wval;
  logic                        io_we;
  logic [hmmd_pkg::DataW-1:0]  rd;
  logic                        fwd;

  assign lo      = addr_q[7:0];
  assign boot_on = (boot_q == '0);

  // owner of an FFxx register outside this block
  always_comb begin
    owned   = 1'b1;
    own_tgt = hmmd_pkg::TGT_INTERNAL;
    if (lo >= 8'h30 && lo <= 8'h3F)                  own_tgt = hmmd_pkg::TGT_AUDIO;
    else if (lo == 8'h4D)                            own_tgt = hmmd_pkg::TGT_CPU;
    else if ((lo >= 8'h40 && lo <= 8'h4C) || lo == 8'h4F ||
             (lo >= 8'h51 && lo <= 8'h55) || (lo >= 8'h68 && lo <= 8'h6B))
                                                     own_tgt = hmmd_pkg::TGT_VIDEO;
    else if (lo == 8'h00)                            own_tgt = hmmd_pkg::TGT_JOYPAD;
    else if (lo >= 8'h04 && lo <= 8'h07)             own_tgt = hmmd_pkg::TGT_TIMER;
    else if ((lo >= 8'h10 && lo <= 8'h14) || (lo >= 8'h16 && lo <= 8'h1E) ||
             (lo >= 8'h20 && lo <= 8'h26))           own_tgt = hmmd_pkg::TGT_AUDIO;
    else if (lo == 8'h01 || lo == 8'h02)             own_tgt = hmmd_pkg::TGT_SERIAL;
    else if (lo == 8'h0F || lo == 8'hFF)             own_tgt = hmmd_pkg::TGT_IRQ;
    else                                             owned   = 1'b0;
  end

  always_comb begin
    tgt  = hmmd_pkg::TGT_INTERNAL;
    kind = K_FWD;
    if (addr_q < 16'h8000) begin
      if (!wr_q && boot_on && !(addr_q >= 16'h0100 && addr_q <= 16'h014F))
        tgt = hmmd_pkg::TGT_BOOT;
      else if (cart_q)
        tgt = hmmd_pkg::TGT_CART;
      else
        kind = K_FILL;
    end else if (addr_q < 16'hA000) begin
      tgt = hmmd_pkg::TGT_VIDEO;
    end else if (addr_q < 16'hC000) begin
      if (cart_q) tgt = hmmd_pkg::TGT_CART;
      else        kind = K_FILL;
    end else if (addr_q < 16'hFE00) begin
      kind = K_WRAM;
    end else if (addr_q < 16'hFEA0) begin
      tgt = hmmd_pkg::TGT_VIDEO;
    end else if (addr_q < 16'hFF00) begin
      kind = K_ZERO;
    end else if (owned) begin
      tgt = own_tgt;
    end else if (addr_q < 16'hFF80) begin
      kind = K_IO;
    end else begin
      kind = K_HRAM;
    end
  end

  // bank 0 at C000/E000, selected bank at D000/F000
  assign widx = addr_q[hmmd_pkg::OffW] ?
                {bank_q, addr_q[hmmd_pkg::OffW-1:0]} :
                {{hmmd_pkg::BankW{1'b0}}, addr_q[hmmd_pkg::OffW-1:0]};
  assign iidx = addr_q[hmmd_pkg::IoAw-1:0];
  assign hidx = addr_q[hmmd_pkg::HramAw-1:0];

  always_comb begin
    io_wval = wdata_q;
    io_we   = cmd_i.access && wr_q && (kind == K_IO);
    if (addr_q == hmmd_pkg::AddrBank) io_wval = wdata_q | BankSetBits;
    // boot latch is sticky once bit 0 is set
    if (addr_q == hmmd_pkg::AddrBoot && boot_q[0]) io_we = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      wr_q    <= req_op_i;
      addr_q  <= req_data_i[hmmd_pkg::AddrW-1:0];
      wdata_q <= req_data_i[hmmd_pkg::InDataW-1:hmmd_pkg::AddrW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      if (wr_q && kind == K_WRAM) wram_mem[widx] <= wdata_q;
      wram_rd_q <= wram_mem[widx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      if (io_we) io_mem[iidx] <= io_wval;
      io_rd_q <= io_mem[iidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      if (wr_q && kind == K_HRAM) hram_mem[hidx] <= wdata_q;
      hram_rd_q <= hram_mem[hidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cart_q   <= 1'b1;
      bank_q   <= hmmd_pkg::BankW'(1);
      boot_q   <= '0;
      io_vld_q <= '0;
      io_rv_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) cart_q <= cfg_data_i;
      if (cmd_i.access) begin
        io_rv_q <= io_vld_q[iidx];
        if (io_we) begin
          io_vld_q[iidx] <= 1'b1;
          if (iidx == BootIdx) boot_q <= wdata_q;
          if (addr_q == hmmd_pkg::AddrBank) begin
            bank_q <= (wdata_q[hmmd_pkg::BankW-1:0] == '0) ?
                      hmmd_pkg::BankW'(1) : wdata_q[hmmd_pkg::BankW-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    case (kind)
      K_FILL:  rd = FillByte;
      K_WRAM:  rd = wram_rd_q;
      K_IO:    rd = io_rv_q ? io_rd_q : '0;
      K_HRAM:  rd = hram_rd_q;
      default: rd = '0;
    endcase
  end

  assign fwd = wr_q && (tgt != hmmd_pkg::TGT_INTERNAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_tgt_q  <= tgt;
      out_data_q <= {6'b0,
                     !wr_q && (tgt == hmmd_pkg::TGT_INTERNAL),
                     (!wr_q && (tgt == hmmd_pkg::TGT_INTERNAL)) ? rd : 8'h00,
                     fwd ? wdata_q : 8'h00,
                     fwd,
                     addr_q};
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_tgt_o         = out_tgt_q;
  assign out_data_o        = out_data_q;

  a_boot_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boot_q[0] |=> boot_q[0])
    else $error("boot latch cleared after being set");

  a_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bank_q != '0)
    else $error("work RAM bank selects zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q)
    else $error("result dropped before it was taken");

endmodule
`default_nettype wire
